[rtl/cddv_pkg.sv]
`timescale 1ns / 1ps

package cddv_pkg;

    // Header and directory layout
    localparam logic [31:0] SIGNATURE        = 32'h504D_444D;
    localparam logic [15:0] VERSION_WORD     = 16'hA793;
    localparam logic [47:0] HDR_BYTES        = 48'd32;
    localparam logic [31:0] HIGHEST_KNOWN    = 32'd24;
    localparam int          MAX_STREAM_COUNT = 10000;

    // Header word positions with checks or actions
    localparam logic [2:0] HPOS_SIGNATURE = 3'd0;
    localparam logic [2:0] HPOS_VERSION   = 3'd1;
    localparam logic [2:0] HPOS_COUNT     = 3'd2;
    localparam logic [2:0] HPOS_DIR       = 3'd3;
    localparam logic [2:0] HPOS_LAST      = 3'd7;

    // Entry word positions
    localparam logic [1:0] EPOS_TYPE   = 2'd0;
    localparam logic [1:0] EPOS_SIZE   = 2'd1;
    localparam logic [1:0] EPOS_OFFSET = 2'd2;

    typedef enum logic [1:0] {
        KIND_DIR_READY = 2'd0,
        KIND_ENTRY     = 2'd1,
        KIND_REJECT    = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_SHORT      = 4'd1,
        ERR_SIGNATURE  = 4'd2,
        ERR_VERSION    = 4'd3,
        ERR_COUNT      = 4'd4,
        ERR_DIR_OFFSET = 4'd5,
        ERR_DIR_FIT    = 4'd6,
        ERR_RANGE      = 4'd7,
        ERR_IN_HEADER  = 4'd8
    } t_error;

    typedef struct packed {
        logic [31:0] word;
        logic        first;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        t_error      error;
        logic [13:0] entry_index;
        logic [31:0] strm_code;
        logic        known_type;
        logic [31:0] payload_ofs;
        logic [31:0] payload_len;
        logic [31:0] dir_ofs;
        logic [13:0] stream_count;
        logic [47:0] dump_bytes;
        logic        last;
    } t_out_item;

endpackage

[rtl/cddv_parse.sv]
`timescale 1ns / 1ps

module cddv_parse #(
    parameter int MAX_STREAM_COUNT = cddv_pkg::MAX_STREAM_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  cddv_pkg::t_in_item  i_item,
    input  logic [47:0]         i_span,
    output logic                o_res_valid,
    output cddv_pkg::t_out_item o_res
);
    import cddv_pkg::*;

    localparam logic [31:0] COUNT_LIMIT = 32'(MAX_STREAM_COUNT);

    logic [2:0]  r_pos,       n_pos;
    logic        r_in_dir,    n_in_dir;
    logic        r_rej,       n_rej;
    logic [13:0] r_entry_cnt, n_entry_cnt;
    logic [13:0] r_decl,      n_decl;
    logic [31:0] r_dir_loc,   n_dir_loc;
    logic [33:0] r_furthest,  n_furthest;
    logic [31:0] r_held_type, n_held_type;
    logic [31:0] r_held_size, n_held_size;

    logic [31:0] w;
    logic [17:0] dir_bytes;
    logic [47:0] dir_end;
    logic [32:0] entry_end;
    logic [33:0] far_max;
    logic [14:0] cnt_plus;
    logic [2:0]  hdr_pos;

    // Shared arithmetic: directory size in bytes (count * 12), directory end, entry end, furthest end and next count
    always_comb begin
        w         = i_item.word;
        dir_bytes = {2'b00, r_decl, 2'b00} + {1'b0, r_decl, 3'b000};
        dir_end   = {16'h0000, w} + {30'h0, dir_bytes};
        entry_end = {1'b0, w} + {1'b0, r_held_size};
        far_max   = ({1'b0, entry_end} > r_furthest) ? {1'b0, entry_end} : r_furthest;
        cnt_plus  = {1'b0, r_entry_cnt} + 15'd1;
    end

    // Next state and result for the word in the input register
    always_comb begin
        n_pos       = r_pos;
        n_in_dir    = r_in_dir;
        n_rej       = r_rej;
        n_entry_cnt = r_entry_cnt;
        n_decl      = r_decl;
        n_dir_loc   = r_dir_loc;
        n_furthest  = r_furthest;
        n_held_type = r_held_type;
        n_held_size = r_held_size;
        hdr_pos     = r_pos;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_item.first) begin
            n_pos       = '0;
            n_in_dir    = 1'b0;
            n_rej       = 1'b0;
            n_entry_cnt = '0;
        end

        if (i_item.first || !r_rej) begin
            if (i_item.first || !r_in_dir) begin
                // header word: check at the current position, then advance
                hdr_pos = n_pos;
                n_pos   = hdr_pos + 3'd1;
                case (hdr_pos)
                    HPOS_SIGNATURE: begin
                        if (i_span < HDR_BYTES) begin
                            o_res_valid = 1'b1;
                            o_res.error = ERR_SHORT;
                        end else if (w != SIGNATURE) begin
                            o_res_valid = 1'b1;
                            o_res.error = ERR_SIGNATURE;
                        end
                    end
                    HPOS_VERSION: begin
                        if (w[15:0] != VERSION_WORD) begin
                            o_res_valid = 1'b1;
                            o_res.error = ERR_VERSION;
                        end
                    end
                    HPOS_COUNT: begin
                        if (w == '0 || w >= COUNT_LIMIT) begin
                            o_res_valid = 1'b1;
                            o_res.error = ERR_COUNT;
                        end else begin
                            n_decl = w[13:0];
                        end
                    end
                    HPOS_DIR: begin
                        if ({16'h0000, w} < HDR_BYTES || {16'h0000, w} >= i_span) begin
                            o_res_valid = 1'b1;
                            o_res.error = ERR_DIR_OFFSET;
                        end else if (dir_end > i_span) begin
                            o_res_valid = 1'b1;
                            o_res.error = ERR_DIR_FIT;
                        end else begin
                            n_dir_loc = w;
                        end
                    end
                    HPOS_LAST: begin
                        n_in_dir           = 1'b1;
                        n_pos              = '0;
                        n_entry_cnt        = '0;
                        n_furthest         = {2'b00, r_dir_loc} + {16'h0, dir_bytes};
                        o_res_valid        = 1'b1;
                        o_res.kind         = KIND_DIR_READY;
                        o_res.dir_ofs      = r_dir_loc;
                        o_res.stream_count = r_decl;
                    end
                    default: begin
                    end
                endcase
                // header rejection
                if (o_res_valid && o_res.error != ERR_NONE) begin
                    o_res.kind = KIND_REJECT;
                    o_res.last = 1'b1;
                    n_rej      = 1'b1;
                end
            end else begin
                // directory entry word
                case (r_pos[1:0])
                    EPOS_TYPE: begin
                        n_held_type = w;
                        n_pos       = 3'd1;
                    end
                    EPOS_SIZE: begin
                        n_held_size = w;
                        n_pos       = 3'd2;
                    end
                    default: begin
                        n_pos       = '0;
                        o_res_valid = 1'b1;
                        if ({15'h0, entry_end} > i_span) begin
                            o_res.kind        = KIND_REJECT;
                            o_res.error       = ERR_RANGE;
                            o_res.entry_index = r_entry_cnt;
                            o_res.last        = 1'b1;
                            n_rej             = 1'b1;
                        end else if (r_held_size != '0 && {16'h0000, w} < HDR_BYTES) begin
                            o_res.kind        = KIND_REJECT;
                            o_res.error       = ERR_IN_HEADER;
                            o_res.entry_index = r_entry_cnt;
                            o_res.last        = 1'b1;
                            n_rej             = 1'b1;
                        end else begin
                            n_furthest        = far_max;
                            o_res.kind        = KIND_ENTRY;
                            o_res.entry_index = r_entry_cnt;
                            o_res.strm_code   = r_held_type;
                            o_res.known_type  = (r_held_type == '0) ||
                                                (r_held_type >= 32'd3 &&
                                                 r_held_type <= HIGHEST_KNOWN);
                            o_res.payload_ofs = w;
                            o_res.payload_len = r_held_size;
                            o_res.stream_count = r_decl;
                            if (cnt_plus >= {1'b0, r_decl}) begin
                                o_res.dump_bytes = ({14'h0, far_max} < i_span) ?
                                                   {14'h0, far_max} : i_span;
                                o_res.last = 1'b1;
                                n_rej      = 1'b1;
                                n_in_dir   = 1'b0;
                            end
                            n_entry_cnt = cnt_plus[13:0];
                        end
                    end
                endcase
            end
        end
    end

    // Advance parse state on each consumed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_in_dir    <= 1'b0;
            r_rej       <= 1'b1;
            r_entry_cnt <= '0;
            r_decl      <= '0;
            r_dir_loc   <= '0;
            r_furthest  <= '0;
            r_held_type <= '0;
            r_held_size <= '0;
        end else if (i_fire) begin
            r_pos       <= n_pos;
            r_in_dir    <= n_in_dir;
            r_rej       <= n_rej;
            r_entry_cnt <= n_entry_cnt;
            r_decl      <= n_decl;
            r_dir_loc   <= n_dir_loc;
            r_furthest  <= n_furthest;
            r_held_type <= n_held_type;
            r_held_size <= n_held_size;
        end
    end

endmodule

[rtl/crash_dump_directory_validator.sv]
`timescale 1ns / 1ps
// Path: an accepted word is held in the input register and checked there; on advance
// its result, if any, is loaded into the result register, from which it is taken.
// Throughput: one word per cycle unless the output stalls; header and entry checks are combinational.
// Reset (synchronous, active low): the parser idles and ignores words until one
// is marked first; file_span clears to zero.

module crash_dump_directory_validator #(
    parameter int MAX_STREAM_COUNT = cddv_pkg::MAX_STREAM_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cddv_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cddv_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [47:0]         i_cfg_data
);
    import cddv_pkg::*;

    logic [47:0] r_span;
    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        advance;
    logic        res_valid;
    t_out_item   res;

    // Consume the held word when the result slot is free or being taken
    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    // Hold file span
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span <= '0;
        end else if (i_cfg_we) begin
            r_span <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    cddv_parse #(
        .MAX_STREAM_COUNT(MAX_STREAM_COUNT)
    ) u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_item     (r_in_item),
        .i_span     (r_span),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    // Result register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_item <= res;
        end
    end

`ifndef SYNTHESIS
    a_reject_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.kind == KIND_REJECT |-> r_out_item.last &&
            r_out_item.error != ERR_NONE)
        else $error("rejection without last or error code");

    a_dir_ready_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.kind == KIND_DIR_READY |->
            !r_out_item.last && r_out_item.error == ERR_NONE)
        else $error("directory-ready word carries last or error");

    a_archive_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_item.kind == KIND_ENTRY && !r_out_item.last |->
            r_out_item.dump_bytes == '0)
        else $error("archive size on non-final entry");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled with empty input register");
`endif

endmodule
